// ===== hdl/mssu_pkg.sv =====
// Package for the MESI snoop state update unit: beat structs, line states,
// tag-store entry layout, bank write port and control states. No dependencies.
`default_nettype none
package mssu_pkg;

  localparam int ADDR_W   = 20;
  localparam int TAG_W    = 12;
  localparam int LINE_W   = 6;
  localparam int LINE_CNT = 64;
  localparam int TAG_LSB  = 8;
  localparam int LINE_LSB = 2;

  typedef enum logic [1:0] {
    MESI_I = 2'd0,
    MESI_S = 2'd1,
    MESI_E = 2'd2,
    MESI_M = 2'd3
  } mesi_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_READX = 1'b1;

  typedef struct packed {
    logic [1:0]        requester;
    logic              opcode;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic       shared;
    logic [1:0] owner_distance;
    logic [1:0] new_state;
  } out_t;

  // bits 13:12 state, bits 11:0 tag
  typedef struct packed {
    mesi_t            st;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] addr;
    entry_t            data;
  } bank_wr_t;

  typedef enum logic {
    CTL_IDLE   = 1'b0,
    CTL_UPDATE = 1'b1
  } ctl_state_t;

endpackage
`default_nettype wire

// ===== hdl/mssu_tag_bank.sv =====
// One core's tag/state bank: 64-entry synchronous memory, registered read.
// Per-line valid flops make unwritten lines read as invalid. Uses mssu_pkg.
`default_nettype none
module mssu_tag_bank
  import mssu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [LINE_W-1:0] rd_addr,
  output entry_t                 rd_data,
  input  bank_wr_t               wr
);

  entry_t              mem [LINE_CNT];
  logic [LINE_CNT-1:0] vld_r;
  entry_t              mem_rd_r;
  logic                vld_rd_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = vld_rd_r ? mem_rd_r : '0;

endmodule
`default_nettype wire

// ===== hdl/mssu_snoop.sv =====
// Snoop and update logic: matches the other cores' entries, finds the
// nearest Modified owner and builds each bank's write-back. Uses mssu_pkg.
`default_nettype none
module mssu_snoop
  import mssu_pkg::*;
#(
  parameter int CORE_COUNT = 4
) (
  input  in_t      item,
  input  entry_t   rd_data [CORE_COUNT],
  input  wire logic go,
  output out_t     result,
  output bank_wr_t wr [CORE_COUNT]
);

  logic [TAG_W-1:0]  tag;
  logic [LINE_W-1:0] line;
  logic              req_ok;
  logic [CORE_COUNT-1:0] hit;
  logic              shared;
  logic [1:0]        own_dist;
  mesi_t             nst;

  assign tag    = item.address[TAG_LSB +: TAG_W];
  assign line   = item.address[LINE_LSB +: LINE_W];
  assign req_ok = (int'(item.requester) < CORE_COUNT);

  always_comb begin
    int c;
    shared   = 1'b0;
    own_dist = 2'd0;
    for (int i = 0; i < CORE_COUNT; i++) begin
      hit[i] = (i != int'(item.requester)) && (rd_data[i].tag == tag) &&
               (rd_data[i].st != MESI_I);
    end
    // walk the ring from the requester, nearest first
    for (int d = 1; d < CORE_COUNT; d++) begin
      c = int'(item.requester) + d;
      if (c >= CORE_COUNT) begin
        c = c - CORE_COUNT;
      end
      if (c < CORE_COUNT && hit[c]) begin
        shared = 1'b1;
        if (rd_data[c].st == MESI_M && own_dist == 2'd0) begin
          own_dist = 2'(d);
        end
      end
    end
    if (item.opcode == OP_READX) begin
      nst = MESI_M;
    end else begin
      nst = shared ? MESI_S : MESI_E;
    end
  end

  always_comb begin
    for (int i = 0; i < CORE_COUNT; i++) begin
      wr[i].addr = line;
      if (i == int'(item.requester)) begin
        wr[i].en   = go && req_ok;
        wr[i].data = '{st: nst, tag: tag};
      end else begin
        wr[i].en   = go && req_ok && hit[i] && ((item.opcode == OP_READX) || shared);
        wr[i].data = '{st: ((item.opcode == OP_READX) ? MESI_I : MESI_S), tag: tag};
      end
    end
  end

  always_comb begin
    if (req_ok) begin
      result.shared         = shared;
      result.owner_distance = own_dist;
      result.new_state      = nst;
    end else begin
      result = '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mesi_snoop_state_update_unit.sv =====
// Top level of the MESI snoop state update unit: control FSM, per-core
// tag banks, snoop logic and result register. Uses mssu_pkg, mssu_tag_bank, mssu_snoop.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_ready  | in_data   (in_t)
//   out_    | output    | out_valid / out_ready| out_data  (out_t)
//
// Beats are taken only in idle: the accept edge reads every bank at the line index,
// and the update state snoops, writes back all banks and loads the result register.
// The result register lets the next beat be read while a result waits;
// the write-back stalls only while that register is full and not taken.
// Reset (rst_n low, synchronous) clears the line valid flops of every bank at once.
`default_nettype none
module mesi_snoop_state_update_unit
  import mssu_pkg::*;
#(
  parameter int CORE_COUNT = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_t       in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  ctl_state_t ctl_state_r, ctl_state_nxt;
  in_t        item_r;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r;

  logic       in_acc;
  logic       go;
  entry_t     rd_data [CORE_COUNT];
  bank_wr_t   wr [CORE_COUNT];
  out_t       result;

  assign in_ready = (ctl_state_r == CTL_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign go       = (ctl_state_r == CTL_UPDATE) && (!out_valid_r || out_ready);

  for (genvar g = 0; g < CORE_COUNT; g++) begin : g_bank
    mssu_tag_bank u_bank (
      .clk     (clk),
      .rst_n   (rst_n),
      .rd_en   (in_acc),
      .rd_addr (in_data.address[LINE_LSB +: LINE_W]),
      .rd_data (rd_data[g]),
      .wr      (wr[g])
    );
  end

  mssu_snoop #(
    .CORE_COUNT (CORE_COUNT)
  ) u_snoop (
    .item    (item_r),
    .rd_data (rd_data),
    .go      (go),
    .result  (result),
    .wr      (wr)
  );

  always_comb begin
    ctl_state_nxt = ctl_state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (ctl_state_r)
      CTL_IDLE: begin
        if (in_acc) begin
          ctl_state_nxt = CTL_UPDATE;
        end
      end
      CTL_UPDATE: begin
        if (go) begin
          ctl_state_nxt = CTL_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: ctl_state_nxt = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_state_r <= CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      ctl_state_r <= ctl_state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_acc_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (ctl_state_r == CTL_UPDATE))
    else $error("accepted beat did not move to update");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((ctl_state_r == CTL_UPDATE) && out_valid_r && !out_ready) |=>
      (ctl_state_r == CTL_UPDATE))
    else $error("write-back left update while result register blocked");

  a_go_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("write-back without a result");

  a_wr_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    wr[0].en |-> (ctl_state_r == CTL_UPDATE))
    else $error("bank write outside update");
`endif

endmodule
`default_nettype wire

// ===== dv/mesi_snoop_state_update_unit_test.sv =====
// Testbench for mesi_snoop_state_update_unit: directed and random bus transactions
// checked against a scoreboard that tracks every core's tag/state store.
// Depends on mssu_pkg and the unit's RTL only.
`timescale 1ns / 1ps
module mesi_snoop_state_update_unit_test
  import mssu_pkg::*;
();

  localparam int TOTAL_BEATS  = 1950;
  localparam int CALM_BEATS   = 300;   // last beats run without idling
  localparam int HOLD_AFTER   = 150;   // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_LIMIT  = 1000;

  class mesi_scoreboard;
    localparam int CORES = 4;
    entry_t banks [CORES][LINE_CNT];
    out_t   expected_q[$];
    int     faults;
    int     results_seen;
    int     requests_seen;
    int     shared_hits;
    int     owner_hits;
    int     readx_count;

    function new();
      foreach (banks[c, l]) banks[c][l] = '{st: MESI_I, tag: '0};
    endfunction

    // Snoop the other cores first, then update requester and matching copies.
    function void note_request(in_t x);
      logic [TAG_W-1:0]  tag;
      logic [LINE_W-1:0] line;
      int                core;
      int                c;
      out_t              res;
      mesi_t             nst;
      tag  = x.address[TAG_LSB +: TAG_W];
      line = x.address[LINE_LSB +: LINE_W];
      core = x.requester;
      res  = '0;
      for (int d = 1; d < CORES; d++) begin
        c = (core + d) % CORES;
        if (banks[c][line].tag == tag && banks[c][line].st != MESI_I) begin
          res.shared = 1'b1;
          if (banks[c][line].st == MESI_M && res.owner_distance == 0)
            res.owner_distance = 2'(d);
        end
      end
      if (x.opcode == OP_READX) nst = MESI_M;
      else nst = res.shared ? MESI_S : MESI_E;
      res.new_state = nst;
      banks[core][line] = '{st: nst, tag: tag};
      if (x.opcode == OP_READX || res.shared) begin
        for (c = 0; c < CORES; c++) begin
          if (c != core && banks[c][line].tag == tag && banks[c][line].st != MESI_I)
            banks[c][line].st = (x.opcode == OP_READX) ? MESI_I : MESI_S;
        end
      end
      requests_seen++;
      if (res.shared) shared_hits++;
      if (res.owner_distance != 0) owner_hits++;
      if (x.opcode == OP_READX) readx_count++;
      expected_q.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result %0d: unexpected beat shared=%0b dist=%0d state=%0d",
                   results_seen, got.shared, got.owner_distance, got.new_state);
        return;
      end
      want = expected_q.pop_front();
      if (got.shared !== want.shared || got.owner_distance !== want.owner_distance ||
          got.new_state !== want.new_state) begin
        faults++;
        if (faults <= 10)
          $display("result %0d: expected shared=%0b dist=%0d state=%0d, got %0b/%0d/%0d",
                   results_seen, want.shared, want.owner_distance, want.new_state,
                   got.shared, got.owner_distance, got.new_state);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  mesi_scoreboard sb = new();
  bit calm;
  bit held_off;
  int quiet;

  mesi_snoop_state_update_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_txn(input logic [1:0] req, input logic op,
                          input logic [ADDR_W-1:0] addr);
    in_valid <= 1'b1;
    in_data  <= '{requester: req, opcode: op, address: addr};
    do @(posedge clk); while (!in_ready);
    sb.note_request('{requester: req, opcode: op, address: addr});
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 9) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // sender
  initial begin
    logic [TAG_W-1:0]  tag_pool [4];
    logic [LINE_W-1:0] line_pool [4];
    logic [ADDR_W-1:0] addr;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // line 0 walks through E, S, M and owner hand-over at distances 1 and 3
    send_txn(2'd0, OP_READ,  20'h00000);
    send_txn(2'd1, OP_READ,  20'h00000);
    send_txn(2'd2, OP_READX, 20'h00003);
    send_txn(2'd3, OP_READ,  20'h00001);
    send_txn(2'd1, OP_READX, 20'h00002);
    send_txn(2'd0, OP_READX, 20'h00000);
    send_txn(2'd1, OP_READ,  20'h00000);
    send_txn(2'd2, OP_READ,  20'h00000);
    // top tag, top line; then same line with different tags
    send_txn(2'd3, OP_READX, 20'hFFFFF);
    send_txn(2'd2, OP_READ,  20'hFFFFF);
    send_txn(2'd1, OP_READ,  20'hFFFFC);
    send_txn(2'd0, OP_READ,  20'hFFEFC);
    send_txn(2'd3, OP_READ,  20'hFFFFD);
    send_txn(2'd2, OP_READX, 20'h000FC);
    send_txn(2'd0, OP_READX, 20'hFFFFE);
    send_txn(2'd3, OP_READ,  20'h000FF);
    send_txn(2'd1, OP_READX, 20'hAAAA8);
    send_txn(2'd2, OP_READ,  20'h55557);
    send_txn(2'd3, OP_READX, 20'hAAAAB);
    send_txn(2'd0, OP_READ,  20'hAAAA9);

    // small pools of tags and lines so that cores keep colliding
    tag_pool  = '{12'h000, 12'hFFF, 12'($urandom), 12'($urandom)};
    line_pool = '{6'd0, 6'd63, 6'($urandom), 6'($urandom)};
    for (int i = 20; i < TOTAL_BEATS; i++) begin
      if (i >= TOTAL_BEATS - CALM_BEATS) calm = 1'b1;
      maybe_gap();
      if ($urandom_range(0, 9) < 8)
        addr = {tag_pool[$urandom_range(0, 3)], line_pool[$urandom_range(0, 3)],
                2'($urandom)};
      else
        addr = 20'($urandom);
      send_txn(2'($urandom), ($urandom_range(0, 99) < 35) ? OP_READX : OP_READ, addr);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d transactions (%0d read-exclusive), %0d results checked",
             sb.requests_seen, sb.readx_count, sb.results_seen);
    $display("snoops: %0d found a sharer, %0d found a modified owner; %0d mismatches",
             sb.shared_hits, sb.owner_hits, sb.faults);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the unit up
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && sb.results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) < 4) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

// ===== files.f =====
hdl/mssu_pkg.sv
hdl/mssu_tag_bank.sv
hdl/mssu_snoop.sv
hdl/mesi_snoop_state_update_unit.sv
dv/mesi_snoop_state_update_unit_test.sv
